// ----- hdl/h264_rtp_fua_packetizer_macros.svh -----
// Assertion helpers used by the packetiser top module.
`ifndef H264_RTP_FUA_PACKETIZER_MACROS_SVH
`define H264_RTP_FUA_PACKETIZER_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define FUA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("packetiser check failed");
// Implication checked in the next cycle.
`define FUA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("packetiser check failed");
`else
`define FUA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FUA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/h264fua_pkg.sv -----
package h264fua_pkg;

  // Fixed field widths and sizes.
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned DefMaxMtu   = 9000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MTU,
    CFG_PT,
    CFG_CHAN,
    CFG_SSRC,
    CFG_RATE,
    CFG_CYCLE,
    CFG_FIRST_SEQ
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_PLAN,
    ST_EMIT
  } fua_state_e;

  // Register reset values.
  localparam logic [13:0] RstMtu       = 14'd1400;
  localparam logic [6:0]  RstPt        = 7'd96;
  localparam logic [7:0]  RstChan      = 8'd0;
  localparam logic [31:0] RstSsrc      = 32'd0;
  localparam logic [7:0]  RstRate      = 8'd90;
  localparam logic [31:0] RstCycle     = 32'd46800000;
  localparam logic [15:0] RstFirstSeq  = 16'd0;

  // Protocol constants.
  localparam logic [13:0] MinMtu       = 14'd16;
  localparam logic [7:0]  InterleaveCh = 8'h24;
  localparam logic [7:0]  RtpVersion   = 8'h80;
  localparam logic [15:0] RtpFixedLen  = 16'd12;
  localparam logic [4:0]  FuAType      = 5'd28;
  localparam logic [4:0]  NalIdr       = 5'd5;

  // Positions in the result sequence of one item.
  localparam logic [4:0] IdxLastHdr = 5'd15;
  localparam logic [4:0] IdxData    = 5'd18;

endpackage

// ----- hdl/h264fua_stream_if.sv -----
// Input channel: one NAL byte per transfer.
interface h264fua_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [23:0] nal_length;
  logic [31:0] stamp_ms;
  modport source (output valid, data_byte, nal_length, stamp_ms, input ready);
  modport sink   (input valid, data_byte, nal_length, stamp_ms, output ready);
endinterface

// Output channel: one packet stream byte per transfer.
interface h264fua_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       marker;
  logic       key_frame;
  logic       run_last;
  modport source (output valid, out_byte, packet_end, marker, key_frame, run_last,
                  input ready);
  modport sink   (input valid, out_byte, packet_end, marker, key_frame, run_last,
                  output ready);
endinterface

// ----- hdl/h264fua_mod_unit.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module h264fua_mod_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic        active_q, active_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] dsr_q, dsr_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] trial;

  // One compare and subtract step per cycle.
  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    dsr_d    = dsr_q;
    rem_d    = rem_q;
    trial    = {rem_q, dvd_q[31]};
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = 5'd31;
      dvd_d    = dividend_i;
      dsr_d    = divisor_i;
      rem_d    = 32'd0;
    end else if (active_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 32'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[31:0];
      end
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= 5'd0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/h264_rtp_fua_packetizer.sv -----
// H.264 RTP packetiser with FU-A fragmentation, RTP-over-RTSP interleaved output.
// Input channel in_i takes one NAL byte per transfer, with the NAL length and a
// millisecond stamp. Output channel out_o gives the packet stream one byte per
// transfer; run_last marks the final byte produced for an input byte.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write it only while idle, as the block itself does not enforce this.
// The first byte of a NAL unit runs the stamp through a 32-step serial remainder
// unit and a multiply, then the plan state and the output register; any other
// byte goes through the plan state and then the output register.
// Input is not taken while a byte is being worked on, so a new byte waits until
// the last one is through; the remainder unit and the output register, one
// result per cycle unless the receiver stalls, set the pace.
// A fragmented NAL's header byte yields no result at all.
// Reset returns the configuration and control registers to their defaults and the
// sequence counter to zero; no clearing pass is needed.
// If the receiver stalls, the output register holds its byte and the sequencer
// waits; nothing is lost or repeated.
`include "h264_rtp_fua_packetizer_macros.svh"

module h264_rtp_fua_packetizer import h264fua_pkg::*; #(
  parameter int unsigned MaxMtu = DefMaxMtu
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  h264fua_in_if.sink  in_i,
  h264fua_out_if.source out_o
);

  fua_state_e state_q, state_d;

  // Configuration registers.
  logic [13:0] mtu_q;
  logic [6:0]  pt_q;
  logic [7:0]  chan_q;
  logic [31:0] ssrc_q;
  logic [7:0]  rate_q;
  logic [31:0] cycle_q;

  // Packetiser state.
  logic [15:0] seq_q, seq_d;
  logic [23:0] off_q, off_d;
  logic [13:0] pleft_q, pleft_d;
  logic        frag_q, frag_d;
  logic        first_q, first_d;
  logic [7:0]  latch_q, latch_d;
  logic [31:0] ts_q;

  // Current item.
  logic [7:0]  b_q;
  logic [23:0] len_q;
  logic [31:0] stamp_q;

  // Plan for the results of the current item.
  logic        hdr_d;
  logic        fu_q, fu_d;
  logic [15:0] rl_q, rl_d;
  logic        hmk_q, hmk_d;
  logic        hkey_q, hkey_d;
  logic [15:0] sq_q;
  logic [7:0]  ind_q, ind_d;
  logic [7:0]  fuh_q, fuh_d;
  logic        dpend_q, dpend_d;
  logic        dmk_q, dmk_d;
  logic        dkey_q, dkey_d;
  logic        skip;
  logic [4:0]  idx_q, idx_d;

  // Output register.
  logic        ovalid_q;
  logic [7:0]  obyte_q;
  logic        opend_q, omk_q, okey_q, olast_q;
  logic [7:0]  byte_sel;

  logic        in_acc, load, mod_start, mod_done;
  logic [31:0] mod_rem, stamp_red;
  logic [13:0] mtu_cl, fsize, frag_len;
  logic [23:0] rem;
  logic        fend;
  logic [23:0] off_pre;
  logic [13:0] pleft_pre, pleft_post;

  assign in_acc    = in_i.valid && in_i.ready;
  assign load      = (state_q == ST_EMIT) && (!ovalid_q || out_o.ready);
  assign mod_start = in_acc && (off_q == 24'd0);

  h264fua_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_i.stamp_ms),
    .divisor_i  (cycle_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign stamp_red = (cycle_q == 32'd0) ? stamp_q : mod_rem;

  // Fragment size from the clamped MTU.
  always_comb begin
    if (mtu_q < MinMtu) begin
      mtu_cl = MinMtu;
    end else if ({3'b0, mtu_q} > 17'(MaxMtu)) begin
      mtu_cl = 14'(MaxMtu);
    end else begin
      mtu_cl = mtu_q;
    end
    fsize = mtu_cl - 14'd2;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = (off_q == 24'd0) ? ST_DIV : ST_PLAN;
      ST_DIV:  if (mod_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_PLAN;
      ST_PLAN: state_d = skip ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (load && (idx_q == IdxData)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
  end

  // Work out the headers and the data byte of the current item.
  always_comb begin
    rem       = (len_q > off_q) ? (len_q - off_q) : 24'd1;
    fend      = 1'b0;
    frag_len  = fsize;
    if (rem <= {10'b0, fsize}) begin
      fend     = 1'b1;
      frag_len = rem[13:0];
      if (first_q && (rem >= 24'd2)) begin
        fend     = 1'b0;
        frag_len = rem[13:0] - 14'd1;
      end
    end

    skip      = 1'b0;
    hdr_d     = 1'b0;
    fu_d      = 1'b0;
    hmk_d     = 1'b0;
    hkey_d    = 1'b0;
    rl_d      = 16'd0;
    ind_d     = {1'b0, latch_q[6:5], FuAType};
    fuh_d     = {first_q, fend, 1'b0, latch_q[4:0]};
    frag_d    = frag_q;
    first_d   = first_q;
    latch_d   = latch_q;
    off_pre   = off_q;
    pleft_pre = pleft_q;

    if (off_q == 24'd0) begin
      if (len_q > {10'b0, fsize}) begin
        // Header byte of a fragmented unit is held back.
        skip      = 1'b1;
        frag_d    = 1'b1;
        first_d   = 1'b1;
        latch_d   = b_q;
        off_pre   = 24'd1;
        pleft_pre = 14'd0;
      end else begin
        hdr_d     = 1'b1;
        frag_d    = 1'b0;
        pleft_pre = len_q[13:0];
        hmk_d     = 1'b1;
        hkey_d    = (b_q[4:0] == NalIdr);
        rl_d      = {2'b0, len_q[13:0]} + RtpFixedLen;
      end
    end else if (pleft_q == 14'd0) begin
      // New FU-A fragment; its indicator type never reads as an IDR.
      hdr_d     = 1'b1;
      fu_d      = 1'b1;
      hmk_d     = fend;
      hkey_d    = 1'b0;
      rl_d      = {2'b0, frag_len} + 16'd2 + RtpFixedLen;
      first_d   = 1'b0;
      pleft_pre = frag_len;
    end

    if (frag_d) begin
      dmk_d  = (({1'b0, off_pre} + 25'(pleft_pre)) >= {1'b0, len_q});
      dkey_d = 1'b0;
    end else begin
      dmk_d  = 1'b1;
      dkey_d = hdr_d && hkey_d;
    end

    pleft_post = (pleft_pre != 14'd0) ? (pleft_pre - 14'd1) : 14'd0;
    dpend_d    = (pleft_post == 14'd0);
    off_d      = off_pre + 24'd1;
    pleft_d    = pleft_post;
    if (dpend_d && (!frag_d || dmk_d)) begin
      off_d   = 24'd0;
      frag_d  = 1'b0;
      first_d = 1'b1;
    end
    if (skip) begin
      off_d   = off_pre;
      pleft_d = pleft_pre;
    end

    seq_d = (hdr_d && !skip) ? (seq_q + 16'd1) : seq_q;
  end

  // Byte at the current emission position.
  always_comb begin
    unique case (idx_q)
      5'd0:    byte_sel = InterleaveCh;
      5'd1:    byte_sel = chan_q;
      5'd2:    byte_sel = rl_q[15:8];
      5'd3:    byte_sel = rl_q[7:0];
      5'd4:    byte_sel = RtpVersion;
      5'd5:    byte_sel = {hmk_q, pt_q};
      5'd6:    byte_sel = sq_q[15:8];
      5'd7:    byte_sel = sq_q[7:0];
      5'd8:    byte_sel = ts_q[31:24];
      5'd9:    byte_sel = ts_q[23:16];
      5'd10:   byte_sel = ts_q[15:8];
      5'd11:   byte_sel = ts_q[7:0];
      5'd12:   byte_sel = ssrc_q[31:24];
      5'd13:   byte_sel = ssrc_q[23:16];
      5'd14:   byte_sel = ssrc_q[15:8];
      5'd15:   byte_sel = ssrc_q[7:0];
      5'd16:   byte_sel = ind_q;
      5'd17:   byte_sel = fuh_q;
      default: byte_sel = b_q;
    endcase
  end

  // Emission position.
  always_comb begin
    idx_d = idx_q;
    if (state_q == ST_PLAN) begin
      idx_d = hdr_d ? 5'd0 : IdxData;
    end else if (load) begin
      idx_d = ((idx_q == IdxLastHdr) && !fu_q) ? IdxData : (idx_q + 5'd1);
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mtu_q    <= RstMtu;
      pt_q     <= RstPt;
      chan_q   <= RstChan;
      ssrc_q   <= RstSsrc;
      rate_q   <= RstRate;
      cycle_q  <= RstCycle;
      seq_q    <= RstFirstSeq;
      off_q    <= 24'd0;
      pleft_q  <= 14'd0;
      frag_q   <= 1'b0;
      first_q  <= 1'b1;
      latch_q  <= 8'd0;
      ts_q     <= 32'd0;
      idx_q    <= 5'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MTU:   mtu_q   <= cfg_data_i[13:0];
          CFG_PT:    pt_q    <= cfg_data_i[6:0];
          CFG_CHAN:  chan_q  <= cfg_data_i[7:0];
          CFG_SSRC:  ssrc_q  <= cfg_data_i;
          CFG_RATE:  rate_q  <= cfg_data_i[7:0];
          CFG_CYCLE: cycle_q <= cfg_data_i;
          // The first sequence number returns to its default on every reset,
          // so a written value never reaches the counter.
          default: begin
          end
        endcase
      end
      if (state_q == ST_MUL) begin
        ts_q <= 32'(rate_q * stamp_red);
      end
      if (state_q == ST_PLAN) begin
        seq_q   <= seq_d;
        off_q   <= off_d;
        pleft_q <= pleft_d;
        frag_q  <= frag_d;
        first_q <= first_d;
        latch_q <= latch_d;
      end
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Item, plan and output payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_q     <= in_i.data_byte;
      len_q   <= (in_i.nal_length == 24'd0) ? 24'd1 : in_i.nal_length;
      stamp_q <= in_i.stamp_ms;
    end
    if (state_q == ST_PLAN) begin
      fu_q    <= fu_d;
      rl_q    <= rl_d;
      hmk_q   <= hmk_d;
      hkey_q  <= hkey_d;
      sq_q    <= seq_q;
      ind_q   <= ind_d;
      fuh_q   <= fuh_d;
      dpend_q <= dpend_d;
      dmk_q   <= dmk_d;
      dkey_q  <= dkey_d;
    end
    if (load) begin
      obyte_q <= byte_sel;
      olast_q <= (idx_q == IdxData);
      opend_q <= (idx_q == IdxData) ? dpend_q : 1'b0;
      omk_q   <= (idx_q == IdxData) ? dmk_q : hmk_q;
      okey_q  <= (idx_q == IdxData) ? dkey_q : hkey_q;
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.packet_end = opend_q;
  assign out_o.marker     = omk_q;
  assign out_o.key_frame  = okey_q;
  assign out_o.run_last   = olast_q;

  // Checks on the sequencer.
  `FUA_ASSERT_IMP(a_in_only_idle, clk_i, rst_ni, in_acc, state_q == ST_IDLE)
  `FUA_ASSERT_IMP(a_div_done_state, clk_i, rst_ni, mod_done, state_q == ST_DIV)
  `FUA_ASSERT_NXT(a_data_last, clk_i, rst_ni, load && (idx_q == IdxData), ovalid_q && olast_q && (state_q == ST_IDLE))
  `FUA_ASSERT_NXT(a_hdr_start, clk_i, rst_ni, (state_q == ST_PLAN) && hdr_d && !skip, idx_q == 5'd0)

endmodule
